@@ sv/rsa_pkg.sv @@
package rsa_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int COUNT_W     = 24;
  localparam int ALIGN_W     = 17;
  localparam int SIZE_W      = 25;
  localparam int STATUS_W    = 2;

  // Wide enough for any offset, size or offset plus count without overflow.
  localparam int CALC_W = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
  localparam int CNT_W  = $clog2(OFFSET_BITS + 1);

  localparam logic [CALC_W-1:0] OFF_SPAN = CALC_W'(1) << OFFSET_BITS;
  localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = 25'h100_0000;

  localparam logic KIND_RESERVE = 1'b0;
  localparam logic KIND_COMMIT  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [COUNT_W-1:0] byte_count;
    logic [ALIGN_W-1:0] alignment;
    logic [COUNT_W-1:0] reader_position;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  start_offset;
  } rsp_t;

  function automatic logic [COUNT_W-1:0] to_count(input logic [OFFSET_BITS-1:0] off);
    logic [CALC_W-1:0] wide;
    wide = CALC_W'(off);
    return wide[COUNT_W-1:0];
  endfunction

endpackage

@@ sv/rsa_modulo.sv @@
module rsa_modulo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [rsa_pkg::OFFSET_BITS-1:0]   dividend,
  input  logic [rsa_pkg::ALIGN_W-1:0]       divisor,
  output logic                              done,
  output logic [rsa_pkg::ALIGN_W-1:0]       remainder
);

  logic [rsa_pkg::OFFSET_BITS-1:0] dividend_sr;
  logic [rsa_pkg::ALIGN_W-1:0]     rem;
  logic [rsa_pkg::ALIGN_W-1:0]     rem_next;
  logic [rsa_pkg::ALIGN_W:0]       trial;
  logic [rsa_pkg::ALIGN_W:0]       diff;
  logic                            fits;
  logic                            running;
  logic [rsa_pkg::CNT_W-1:0]       count;

  // Restoring remainder, one dividend bit per cycle from the top.
  always_comb begin
    trial    = {rem, dividend_sr[rsa_pkg::OFFSET_BITS-1]};
    fits     = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    rem_next = fits ? diff[rsa_pkg::ALIGN_W-1:0] : trial[rsa_pkg::ALIGN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count   <= rsa_pkg::CNT_W'(rsa_pkg::OFFSET_BITS);
      end else if (running) begin
        count <= count - rsa_pkg::CNT_W'(1);
        if (count == rsa_pkg::CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dividend_sr <= dividend;
      rem         <= '0;
    end else if (running) begin
      dividend_sr <= dividend_sr << 1;
      rem         <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

@@ sv/ring_stream_allocator_core.sv @@
// Ring-buffer space allocator.
// Items come in on req and are taken at a clock edge where start is high and
// busy is low. Each item gives exactly one result beat on rsp, shown for one
// cycle with done high; the receiver has no way to hold it off.
// A reserve asks for byte_count plus alignment free bytes, first up to the
// buffer end, then by wrapping to zero before the reader, or between the
// write offset and the reader. A granted offset is rounded up to the
// alignment, which may be any value from one to 2^17 - 1; zero counts as one.
// A commit, a failed reserve or a reserve that wraps to zero is settled in
// S_DECIDE, which registers its result beat. A reserve that needs rounding
// passes through S_DECIDE and S_DIVIDE: the remainder of the write offset
// by the alignment comes from a bit-serial unit that consumes one offset bit
// per cycle. A new item may be taken in the cycle its predecessor's result
// is shown.
// buffer_size is written on the cfg channel, which is ready whenever busy is
// low. Reset clears the write offset and the last reservation and sets
// buffer_size to 2^24; the block is ready in the first cycle after reset.
module ring_stream_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  rsa_pkg::req_t               req,
  output logic                        done,
  output rsa_pkg::rsp_t               rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rsa_pkg::SIZE_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_DIVIDE} state_t;
  typedef enum logic [1:0] {OUT_FAIL, OUT_WRAP, OUT_ROUND} outcome_t;

  state_t state;

  logic [rsa_pkg::OFFSET_BITS-1:0] write_offset;
  logic [rsa_pkg::COUNT_W-1:0]     last_reserved_bytes;
  logic [rsa_pkg::SIZE_W-1:0]      buffer_size;

  logic                            kind_q;
  logic [rsa_pkg::COUNT_W-1:0]     bytes_q;
  logic [rsa_pkg::ALIGN_W-1:0]     align_q;
  logic [rsa_pkg::COUNT_W-1:0]     reader_q;

  logic [rsa_pkg::CALC_W-1:0]      size_c;
  logic [rsa_pkg::CALC_W-1:0]      wo_c;
  logic [rsa_pkg::CALC_W-1:0]      rd_c;
  logic [rsa_pkg::CALC_W-1:0]      need;
  logic [rsa_pkg::CALC_W-1:0]      room;
  logic [rsa_pkg::CALC_W-1:0]      commit_next;
  logic [rsa_pkg::CALC_W-1:0]      rounded;
  logic                            commit_bad;
  outcome_t                        outcome;

  logic                            div_go;
  logic                            div_done;
  logic [rsa_pkg::ALIGN_W-1:0]     div_rem;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    size_c = (rsa_pkg::CALC_W'(buffer_size) > rsa_pkg::OFF_SPAN) ?
             rsa_pkg::OFF_SPAN : rsa_pkg::CALC_W'(buffer_size);
    wo_c   = rsa_pkg::CALC_W'(write_offset);
    rd_c   = rsa_pkg::CALC_W'(reader_q);
    need   = rsa_pkg::CALC_W'(bytes_q) + rsa_pkg::CALC_W'(align_q);
    room   = (wo_c <= size_c) ? (size_c - wo_c) : '0;

    if (wo_c >= rd_c) begin
      if (need <= room) begin
        outcome = OUT_ROUND;
      end else if (need <= rd_c) begin
        outcome = OUT_WRAP;
      end else begin
        outcome = OUT_FAIL;
      end
    end else if (need <= rd_c - wo_c) begin
      outcome = OUT_ROUND;
    end else begin
      outcome = OUT_FAIL;
    end

    commit_next = wo_c + rsa_pkg::CALC_W'(bytes_q);
    commit_bad  = (commit_next > size_c) || (commit_next >= rsa_pkg::OFF_SPAN) ||
                  (bytes_q > last_reserved_bytes);

    // A zero remainder means the offset is already aligned.
    rounded = (div_rem == '0) ? wo_c :
              wo_c + rsa_pkg::CALC_W'(align_q) - rsa_pkg::CALC_W'(div_rem);
  end

  assign div_go = (state == S_DECIDE) && (kind_q == rsa_pkg::KIND_RESERVE) &&
                  (outcome == OUT_ROUND);

  rsa_modulo u_modulo (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (write_offset),
    .divisor   (align_q),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      done                <= 1'b0;
      write_offset        <= '0;
      last_reserved_bytes <= '0;
      buffer_size         <= rsa_pkg::BUFFER_SIZE_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        buffer_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (kind_q == rsa_pkg::KIND_COMMIT) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (commit_bad) begin
              rsp.status       <= rsa_pkg::STATUS_REJECTED;
              rsp.start_offset <= rsa_pkg::to_count(write_offset);
            end else begin
              write_offset     <= commit_next[rsa_pkg::OFFSET_BITS-1:0];
              rsp.status       <= rsa_pkg::STATUS_OK;
              rsp.start_offset <= rsa_pkg::to_count(commit_next[rsa_pkg::OFFSET_BITS-1:0]);
            end
          end else begin
            case (outcome)
              OUT_ROUND: begin
                state <= S_DIVIDE;
              end
              OUT_WRAP: begin
                state               <= S_IDLE;
                done                <= 1'b1;
                write_offset        <= '0;
                last_reserved_bytes <= bytes_q;
                rsp.status          <= rsa_pkg::STATUS_OK;
                rsp.start_offset    <= '0;
              end
              default: begin
                state            <= S_IDLE;
                done             <= 1'b1;
                rsp.status       <= rsa_pkg::STATUS_NO_SPACE;
                rsp.start_offset <= rsa_pkg::to_count(write_offset);
              end
            endcase
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            state               <= S_IDLE;
            done                <= 1'b1;
            write_offset        <= rounded[rsa_pkg::OFFSET_BITS-1:0];
            last_reserved_bytes <= bytes_q;
            rsp.status          <= rsa_pkg::STATUS_OK;
            rsp.start_offset    <= rsa_pkg::to_count(rounded[rsa_pkg::OFFSET_BITS-1:0]);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The item is held for the whole of its work; zero alignment counts as one.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_q   <= req.kind;
      bytes_q  <= req.byte_count;
      align_q  <= (req.alignment == '0) ? rsa_pkg::ALIGN_W'(1) : req.alignment;
      reader_q <= req.reader_position;
    end
  end

endmodule

@@ sv/rsa_checker.sv @@
module rsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input rsa_pkg::rsp_t               rsp,
  input logic                        cfg_ready
);

  logic [rsa_pkg::COUNT_W-1:0] shown_offset;

  // The write offset as the last result beat showed it; zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      shown_offset <= '0;
    end else if (done) begin
      shown_offset <= rsp.start_offset;
    end
  end

  // A result beat always ends the work of an item.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && cfg_ready)
    else $error("result beat while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy && !done)
    else $error("accepted item did not make the block busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without work before it");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == rsa_pkg::STATUS_OK) ||
             (rsp.status == rsa_pkg::STATUS_NO_SPACE) ||
             (rsp.status == rsa_pkg::STATUS_REJECTED))
    else $error("illegal status code");

  // A reserve without space or a rejected commit leaves the write offset alone.
  a_fail_keeps_offset: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != rsa_pkg::STATUS_OK)) |-> (rsp.start_offset == shown_offset))
    else $error("failed item moved the write offset");

endmodule

bind ring_stream_allocator_core rsa_checker u_rsa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .rsp       (rsp),
  .cfg_ready (cfg_ready)
);
